// ----- design/dpss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive power-state sequencer package
// Shared state, command and error codes, and the command word table.
// ----------------------------------------------------------------------------
package dpss_pkg;

  typedef enum logic [2:0] {
    ST_NOTREADY   = 3'd0,
    ST_SODISABLED = 3'd1,
    ST_READY      = 3'd2,
    ST_SWITCHEDON = 3'd3,
    ST_OPENABLED  = 3'd4,
    ST_QUICKSTOP  = 3'd5,
    ST_FAULTREACT = 3'd6,
    ST_FAULT      = 3'd7
  } pstate_t;

  typedef enum logic [2:0] {
    CMD_DISABLE  = 3'd0,
    CMD_SHUTDOWN = 3'd1,
    CMD_SWITCHON = 3'd2,
    CMD_ENABLE   = 3'd3,
    CMD_QSTOP    = 3'd4,
    CMD_FRESET   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_BAD_STATUS  = 2'd1,
    ERR_UNREACHABLE = 2'd2
  } err_t;

  localparam logic [6:0] STATUS_MASK_A = 7'h4F;
  localparam logic [6:0] STATUS_MASK_B = 7'h6F;
  localparam logic [6:0] PAT_NOTREADY   = 7'h00;
  localparam logic [6:0] PAT_SODISABLED = 7'h40;
  localparam logic [6:0] PAT_FAULTREACT = 7'h0F;
  localparam logic [6:0] PAT_FAULT      = 7'h08;
  localparam logic [6:0] PAT_READY      = 7'h21;
  localparam logic [6:0] PAT_SWITCHEDON = 7'h23;
  localparam logic [6:0] PAT_OPENABLED  = 7'h27;
  localparam logic [6:0] PAT_QUICKSTOP  = 7'h07;

  typedef struct packed {
    logic    valid;
    pstate_t state;
    logic    op_enabled;
  } decode_t;

  function automatic logic [15:0] cmd_word(input cmd_t cmd);
    logic [15:0] w;
    case (cmd)
      CMD_DISABLE:  w = 16'h0000;
      CMD_SHUTDOWN: w = 16'h0006;
      CMD_SWITCHON: w = 16'h0007;
      CMD_ENABLE:   w = 16'h000F;
      CMD_QSTOP:    w = 16'h0002;
      CMD_FRESET:   w = 16'h0080;
      default:      w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

// ----- design/dpss_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status word decoder
// Maps status bits 0-6 to a power state and derives operation enabled.
// ----------------------------------------------------------------------------
module dpss_decode import dpss_pkg::*; (
  input  logic [15:0] status,
  output decode_t     dec
);

  logic [6:0] pat_a;
  logic [6:0] pat_b;

  assign pat_a = status[6:0] & STATUS_MASK_A;
  assign pat_b = status[6:0] & STATUS_MASK_B;

  always_comb begin
    dec.valid = 1'b1;
    dec.state = ST_NOTREADY;
    // operation enabled: bits 0,1,2,5 set, fault bit clear
    dec.op_enabled = ~status[3] & status[0] & status[1] &
                     status[2] & status[5];
    if (pat_a == PAT_NOTREADY) begin
      dec.state = ST_NOTREADY;
    end else if (pat_a == PAT_SODISABLED) begin
      dec.state = ST_SODISABLED;
    end else if (pat_a == PAT_FAULTREACT) begin
      dec.state = ST_FAULTREACT;
    end else if (pat_a == PAT_FAULT) begin
      dec.state = ST_FAULT;
    end else if (pat_b == PAT_READY) begin
      dec.state = ST_READY;
    end else if (pat_b == PAT_SWITCHEDON) begin
      dec.state = ST_SWITCHEDON;
    end else if (pat_b == PAT_OPENABLED) begin
      dec.state = ST_OPENABLED;
    end else if (pat_b == PAT_QUICKSTOP) begin
      dec.state = ST_QUICKSTOP;
    end else begin
      dec.valid = 1'b0;
    end
  end

endmodule

// ----- design/dpss_cmd_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command selector
// Picks the next command from the transition table and keeps the last one.
// ----------------------------------------------------------------------------
module dpss_cmd_select import dpss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    clear_faults,
  input  decode_t dec,
  input  pstate_t goal,
  output cmd_t    next_cmd,
  output err_t    err
);

  cmd_t last_command;
  cmd_t fr_cmd;
  cmd_t trans_cmd;

  assign fr_cmd = (last_command == CMD_DISABLE) ? CMD_FRESET : CMD_DISABLE;

  always_comb begin
    trans_cmd = CMD_DISABLE;
    if (dec.state == ST_FAULT) begin
      trans_cmd = fr_cmd;
    end else begin
      unique case (goal)
        ST_SODISABLED: begin
          trans_cmd = (dec.state == ST_OPENABLED) ? CMD_QSTOP : CMD_DISABLE;
        end
        ST_READY: begin
          if (dec.state == ST_OPENABLED) trans_cmd = CMD_QSTOP;
          else if (dec.state == ST_QUICKSTOP) trans_cmd = CMD_DISABLE;
          else trans_cmd = CMD_SHUTDOWN;
        end
        ST_SWITCHEDON: begin
          if (dec.state == ST_SODISABLED) trans_cmd = CMD_SHUTDOWN;
          else if (dec.state == ST_READY) trans_cmd = CMD_SWITCHON;
          else if (dec.state == ST_OPENABLED) trans_cmd = CMD_QSTOP;
          else trans_cmd = CMD_DISABLE;
        end
        ST_OPENABLED: begin
          if (dec.state == ST_SODISABLED) trans_cmd = CMD_SHUTDOWN;
          else if (dec.state == ST_READY) trans_cmd = CMD_SWITCHON;
          else trans_cmd = CMD_ENABLE;
        end
        default: begin
          if (dec.state == ST_SODISABLED) trans_cmd = CMD_SHUTDOWN;
          else if (dec.state == ST_READY) trans_cmd = CMD_SWITCHON;
          else if (dec.state == ST_SWITCHEDON) trans_cmd = CMD_ENABLE;
          else trans_cmd = CMD_QSTOP;
        end
      endcase
    end
  end

  always_comb begin
    next_cmd = last_command;
    err      = ERR_OK;
    if (!dec.valid) begin
      err = ERR_BAD_STATUS;
    end else if (dec.state == goal) begin
      // a held fault reset is not repeated
      next_cmd = (last_command == CMD_FRESET) ? CMD_DISABLE : last_command;
    end else if (dec.state == ST_NOTREADY || dec.state == ST_FAULTREACT ||
                 (dec.state == ST_FAULT && !clear_faults)) begin
      next_cmd = last_command;
    end else if (goal == ST_NOTREADY || goal == ST_FAULTREACT || goal == ST_FAULT) begin
      err = ERR_UNREACHABLE;
    end else begin
      next_cmd = trans_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_command <= CMD_DISABLE;
    end else if (advance && err == ERR_OK) begin
      last_command <= next_cmd;
    end
  end

endmodule

// ----- design/drive_power_state_sequencer_core.sv -----
`timescale 1ns / 1ps
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle while m_axis_tready is high; decode and
// command selection sit between the two registers, with last_command fed back.
// Reset: synchronous, active high; clears both valid flags, clear_faults and
// the held command (disable voltage).
// ----------------------------------------------------------------------------
// Drive power-state sequencer
// Decodes drive status and sequences control words towards a goal state.
// ----------------------------------------------------------------------------
module drive_power_state_sequencer_core import dpss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,       // clear_faults
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // status[15:0], goal[18:16], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // ctrl[15:0], drive_state[18:16],
                                       // error_code[20:19], operation_enabled[21], zero pad
);

  logic        clear_faults;
  logic        in_valid;
  logic [15:0] in_status;
  pstate_t     in_goal;
  logic        advance;
  decode_t     dec;
  cmd_t        next_cmd;
  err_t        err;
  logic        out_valid;
  logic [21:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_faults <= 1'b0;
    end else if (cfg_we) begin
      clear_faults <= cfg_wdata;
    end
  end

  // advance the input beat into the result register when that slot frees up
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_status <= s_axis_tdata[15:0];
      in_goal   <= pstate_t'(s_axis_tdata[18:16]);
    end
  end

  dpss_decode u_decode (
    .status (in_status),
    .dec    (dec)
  );

  dpss_cmd_select u_cmd_select (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .clear_faults (clear_faults),
    .dec          (dec),
    .goal         (in_goal),
    .next_cmd     (next_cmd),
    .err          (err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {dec.op_enabled, err, dec.state, cmd_word(next_cmd)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

endmodule

// ----- sim/drive_power_state_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive power-state sequencer checker
// Watches the configuration port and both streams. It keeps its own copy of
// the held command and the fault-clearing mode, works out the response to
// each input beat, and compares every output beat with the oldest one due.
// ----------------------------------------------------------------------------
module drive_power_state_checker import dpss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // status[15:0], goal[18:16], zero pad
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,    // ctrl[15:0], drive_state[18:16],
                                       // error_code[20:19], operation_enabled[21], zero pad
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] ctrl_word;
    pstate_t     drive_state;
    err_t        error_code;
    logic        op_enabled;
  } drive_response_t;

  drive_response_t responses_due[$];
  cmd_t            held_cmd;
  logic            clear_faults_q;
  int              mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [15:0] command_code_word(input cmd_t cmd);
    case (cmd)
      CMD_SHUTDOWN: return 16'h0006;
      CMD_SWITCHON: return 16'h0007;
      CMD_ENABLE:   return 16'h000F;
      CMD_QSTOP:    return 16'h0002;
      CMD_FRESET:   return 16'h0080;
      default:      return 16'h0000;
    endcase
  endfunction

  // The mask-A patterns take priority over the mask-B ones.
  function automatic logic status_to_state(input logic [6:0] bits, output pstate_t st);
    logic [6:0] a;
    logic [6:0] b;
    a  = bits & STATUS_MASK_A;
    b  = bits & STATUS_MASK_B;
    st = ST_NOTREADY;
    if (a == PAT_NOTREADY)        st = ST_NOTREADY;
    else if (a == PAT_SODISABLED) st = ST_SODISABLED;
    else if (a == PAT_FAULTREACT) st = ST_FAULTREACT;
    else if (a == PAT_FAULT)      st = ST_FAULT;
    else if (b == PAT_READY)      st = ST_READY;
    else if (b == PAT_SWITCHEDON) st = ST_SWITCHEDON;
    else if (b == PAT_OPENABLED)  st = ST_OPENABLED;
    else if (b == PAT_QUICKSTOP)  st = ST_QUICKSTOP;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic cmd_t step_command(input pstate_t cur, input pstate_t goal,
                                        input cmd_t fault_cmd);
    if (cur == ST_FAULT) return fault_cmd;
    case (goal)
      ST_SODISABLED: return (cur == ST_OPENABLED) ? CMD_QSTOP : CMD_DISABLE;
      ST_READY: begin
        if (cur == ST_OPENABLED) return CMD_QSTOP;
        if (cur == ST_QUICKSTOP) return CMD_DISABLE;
        return CMD_SHUTDOWN;
      end
      ST_SWITCHEDON: begin
        if (cur == ST_SODISABLED) return CMD_SHUTDOWN;
        if (cur == ST_READY) return CMD_SWITCHON;
        if (cur == ST_OPENABLED) return CMD_QSTOP;
        return CMD_DISABLE;
      end
      ST_OPENABLED: begin
        if (cur == ST_SODISABLED) return CMD_SHUTDOWN;
        if (cur == ST_READY) return CMD_SWITCHON;
        return CMD_ENABLE;
      end
      default: begin
        if (cur == ST_SODISABLED) return CMD_SHUTDOWN;
        if (cur == ST_READY) return CMD_SWITCHON;
        if (cur == ST_SWITCHEDON) return CMD_ENABLE;
        return CMD_QSTOP;
      end
    endcase
  endfunction

  // Works out one response and advances the held command.
  function automatic drive_response_t sequence_drive(input logic [15:0] status,
                                                     input pstate_t goal);
    drive_response_t r;
    pstate_t         cur;
    cmd_t            prev;
    cmd_t            next;
    prev         = held_cmd;
    next         = prev;
    r.error_code = ERR_OK;
    r.op_enabled = !status[3] && ((status & 16'h0027) == 16'h0027);
    if (!status_to_state(status[6:0], cur)) begin
      r.error_code = ERR_BAD_STATUS;
      cur          = ST_NOTREADY;
    end else if (cur == goal) begin
      // a fault reset held when the goal is reached is not sent again
      next = (prev == CMD_FRESET) ? CMD_DISABLE : prev;
    end else if (cur == ST_NOTREADY || cur == ST_FAULTREACT ||
                 (cur == ST_FAULT && !clear_faults_q)) begin
      next = prev;
    end else if (goal == ST_NOTREADY || goal == ST_FAULTREACT || goal == ST_FAULT) begin
      r.error_code = ERR_UNREACHABLE;
    end else begin
      next = step_command(cur, goal, (prev == CMD_DISABLE) ? CMD_FRESET : CMD_DISABLE);
    end
    if (r.error_code == ERR_OK) held_cmd = next;
    r.ctrl_word   = command_code_word(next);
    r.drive_state = cur;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_response_t due;
    drive_response_t seen;
    if (rst) begin
      held_cmd       = CMD_DISABLE;
      clear_faults_q = 1'b0;
      responses_due.delete();
      pending <= 0;
    end else begin
      if (cfg_we) clear_faults_q = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        responses_due.push_back(sequence_drive(s_axis_tdata[15:0],
                                               pstate_t'(s_axis_tdata[18:16])));
      if (m_axis_tvalid && m_axis_tready) begin
        seen.ctrl_word   = m_axis_tdata[15:0];
        seen.drive_state = pstate_t'(m_axis_tdata[18:16]);
        seen.error_code  = err_t'(m_axis_tdata[20:19]);
        seen.op_enabled  = m_axis_tdata[21];
        if (responses_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: output beat %h with nothing outstanding", $realtime, m_axis_tdata);
        end else begin
          due = responses_due.pop_front();
          if (seen !== due || m_axis_tdata[23:22] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch  word %h/%h  state %0d/%0d  error %0d/%0d", $realtime,
                     due.ctrl_word, seen.ctrl_word, due.drive_state,
                     seen.drive_state, due.error_code, seen.error_code);
              $display("  op_en %b/%b  pad %b (expected/actual)",
                       due.op_enabled, seen.op_enabled, m_axis_tdata[23:22]);
            end
          end
        end
      end
      pending <= responses_due.size();
    end
  end

endmodule

// ----- sim/drive_power_state_sequencer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive power-state sequencer regression
// Drives status words and goal states in bursts, with a stalling receiver,
// across both fault-clearing modes; the checker flags any wrong response.
// ----------------------------------------------------------------------------
module drive_power_state_sequencer_core_test import dpss_pkg::*; ;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;     // status[15:0], goal[18:16], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;     // ctrl[15:0], drive_state[18:16],
                                 // error_code[20:19], operation_enabled[21], zero pad
  int          fail_count;
  int          pending;
  int          sent_beats = 0;
  int          burst_left = 0;
  logic        long_hold_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  drive_power_state_sequencer_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  drive_power_state_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Valid pattern for a state, with every don't-care bit random.
  function automatic logic [15:0] status_for(input pstate_t st);
    logic [15:0] pat;
    logic [15:0] mask;
    mask = {9'd0, STATUS_MASK_A};
    case (st)
      ST_NOTREADY:   pat = {9'd0, PAT_NOTREADY};
      ST_SODISABLED: pat = {9'd0, PAT_SODISABLED};
      ST_FAULTREACT: pat = {9'd0, PAT_FAULTREACT};
      ST_FAULT:      pat = {9'd0, PAT_FAULT};
      ST_READY:      pat = {9'd0, PAT_READY};
      ST_SWITCHEDON: pat = {9'd0, PAT_SWITCHEDON};
      ST_OPENABLED:  pat = {9'd0, PAT_OPENABLED};
      default:       pat = {9'd0, PAT_QUICKSTOP};
    endcase
    if (st inside {ST_READY, ST_SWITCHEDON, ST_OPENABLED, ST_QUICKSTOP})
      mask = {9'd0, STATUS_MASK_B};
    return (16'($urandom) & ~mask) | pat;
  endfunction

  function automatic pstate_t pick_goal();
    if ($urandom_range(0, 3) == 0) return pstate_t'($urandom_range(0, 7));
    return pstate_t'($urandom_range(1, 5));
  endfunction

  task automatic push_beat(input logic [15:0] status, input pstate_t goal);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, goal, status};
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    sent_beats <= sent_beats + 1;
  endtask

  // Hold the input until every outstanding response has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_clear_faults(input logic mode);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: changing stall patterns, plus one long hold-off to back the
  // block up while the sender keeps offering beats.
  initial begin
    int mode;
    int span;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!long_hold_done && sent_beats >= 80) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 40);
      repeat (span) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int      n;
    int      reps;
    pstate_t st;
    pstate_t goal;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: faults preserved
    push_beat(16'h0000, ST_SODISABLED);
    push_beat(16'hFFFF, ST_FAULT);
    push_beat(status_for(ST_SODISABLED), ST_READY);
    push_beat(status_for(ST_READY), ST_SWITCHEDON);
    push_beat(status_for(ST_SWITCHEDON), ST_OPENABLED);
    push_beat(status_for(ST_OPENABLED), ST_OPENABLED);
    push_beat(status_for(ST_OPENABLED), ST_QUICKSTOP);
    push_beat(status_for(ST_QUICKSTOP), ST_READY);
    push_beat(status_for(ST_SODISABLED), ST_FAULT);
    push_beat(status_for(ST_SODISABLED), ST_NOTREADY);
    push_beat(status_for(ST_READY), ST_FAULTREACT);
    push_beat(status_for(ST_FAULTREACT), ST_OPENABLED);
    push_beat(status_for(ST_FAULT), ST_SODISABLED);
    push_beat(status_for(ST_OPENABLED), ST_SODISABLED);
    push_beat(status_for(ST_SWITCHEDON), ST_QUICKSTOP);
    push_beat(16'h007F, ST_READY);

    // directed: faults cleared, alternating reset and disable
    set_clear_faults(1'b1);
    repeat (4) push_beat(status_for(ST_FAULT), ST_SODISABLED);
    push_beat(status_for(ST_FAULT), ST_FAULT);
    push_beat(status_for(ST_FAULT), ST_FAULT);
    push_beat(16'hFFF0, ST_SODISABLED);
    push_beat(status_for(ST_QUICKSTOP), ST_SWITCHEDON);

    // random: runs of one drive state with noise beats mixed in
    for (int phase = 0; phase < 4; phase++) begin
      set_clear_faults(phase[0]);
      n = 0;
      while (n < 150) begin
        if ($urandom_range(0, 6) == 0) begin
          push_beat(16'($urandom), pstate_t'($urandom_range(0, 7)));
          n++;
        end else begin
          reps = $urandom_range(1, 4);
          st   = ($urandom_range(0, 9) >= 8) ? ST_FAULT : pstate_t'($urandom_range(0, 7));
          goal = pick_goal();
          repeat (reps) begin
            push_beat(status_for(st), goal);
            n++;
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
design/dpss_pkg.sv
design/dpss_decode.sv
design/dpss_cmd_select.sv
design/drive_power_state_sequencer_core.sv
sim/drive_power_state_checker.sv
sim/drive_power_state_sequencer_core_test.sv
